[src/frame_rate_window_monitor_assert.svh]
// Assertion macros shared by the frame rate window monitor RTL.
// Each macro takes a label, the clock, the active-low reset, an antecedent, a consequent and a message.
`ifndef FRAME_RATE_WINDOW_MONITOR_ASSERT_SVH
`define FRAME_RATE_WINDOW_MONITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRWM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRWM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/frwm_pkg.sv]
// Package of the frame rate window monitor: field widths, reset constants and the
// divider request type. Depends on nothing.
`default_nettype none

package frwm_pkg;

    localparam int unsigned RATE_W            = 24;
    localparam int unsigned TPS_W             = 32;
    localparam int unsigned WINDOW_DEPTH_DEF  = 16;
    localparam int unsigned DIV_STEPS         = 24;
    localparam int unsigned DIV_CNT_W         = $clog2(DIV_STEPS);

    localparam logic [RATE_W-1:0] RATE_MAX  = 24'hFFFFFF;
    localparam logic [RATE_W-1:0] MIN_RESET = 24'd2559744;
    localparam logic [TPS_W-1:0]  TPS_RESET = 32'd1000000;

    // Request to the shared serial divider. The dividend is {rem_init, numer}, where
    // rem_init must already be below the divisor so that the quotient fits RATE_W bits.
    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] rem_init;
        logic [RATE_W-1:0] numer;
        logic [RATE_W-1:0] divisor;
    } div_cmd_t;

endpackage

`default_nettype wire

[src/frwm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on frwm_pkg only for default parameter values.
`default_nettype none

module frwm_ram #(
    parameter int unsigned WIDTH = frwm_pkg::RATE_W,
    parameter int unsigned DEPTH = frwm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/frwm_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, DIV_STEPS quotient bits in all.
// Depends on frwm_pkg for widths and the request type.
`default_nettype none

module frwm_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  frwm_pkg::div_cmd_t        div_cmd,
    output logic                      busy,
    output logic [frwm_pkg::RATE_W-1:0] quotient
);
    import frwm_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [RATE_W-1:0]    numer_reg, numer_next;
    logic [RATE_W-1:0]    divisor_reg, divisor_next;
    logic [RATE_W-1:0]    quot_reg, quot_next;

    logic [RATE_W:0]      trial;
    logic [RATE_W:0]      diff;
    logic                 fits;

    // The remainder stays below the divisor, so the shifted trial needs one extra bit only.
    assign trial = {rem_reg, numer_reg[RATE_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        numer_next   = numer_reg;
        divisor_next = divisor_reg;
        quot_next    = quot_reg;
        if (div_cmd.start) begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = div_cmd.rem_init;
            numer_next   = div_cmd.numer;
            divisor_next = div_cmd.divisor;
        end else if (busy_reg) begin
            rem_next   = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            numer_next = {numer_reg[RATE_W-2:0], 1'b0};
            quot_next  = {quot_reg[RATE_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        numer_reg   <= numer_next;
        divisor_reg <= divisor_next;
        quot_reg    <= quot_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

[src/frame_rate_window_monitor.sv]
// Frame rate window monitor. An accepted request passes through the rate quotient, the
// window update, the average quotient and the handoff to the output registers before
// m_valid. A new request is taken only once the result is loaded; both quotients share
// the one serial divider, and a low m_ready holds back the result load. Synchronous reset
// clears the window (no clearing pass), the statistics and the tick rate to 1000000.
// Depends on frwm_pkg, frwm_div, frwm_ram and frame_rate_window_monitor_assert.svh.
`default_nettype none

`include "frame_rate_window_monitor_assert.svh"

module frame_rate_window_monitor #(
    parameter int unsigned WINDOW_DEPTH = frwm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [frwm_pkg::TPS_W-1:0]  cfg_ticks_per_second,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [frwm_pkg::RATE_W-1:0] s_interval_ticks,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [frwm_pkg::RATE_W-1:0] m_frame_rate,
    output logic                        m_rate_recorded,
    output logic                        m_rate_saturated,
    output logic [frwm_pkg::RATE_W-1:0] m_lowest_rate,
    output logic [frwm_pkg::RATE_W-1:0] m_highest_rate,
    output logic [frwm_pkg::RATE_W-1:0] m_average_rate
);
    import frwm_pkg::*;

    localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int unsigned SUM_W  = RATE_W + SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RATE   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_AVG    = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [TPS_W-1:0]   tps_reg, tps_next;
    logic               sat_reg, sat_next;
    logic [1:0]         seen_reg, seen_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               full_reg, full_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [RATE_W-1:0]  min_reg, min_next;
    logic [RATE_W-1:0]  max_reg, max_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic               recorded_reg, recorded_next;

    logic               m_valid_reg, m_valid_next;
    logic [RATE_W-1:0]  m_frame_rate_reg, m_frame_rate_next;
    logic               m_rate_recorded_reg, m_rate_recorded_next;
    logic               m_rate_saturated_reg, m_rate_saturated_next;
    logic [RATE_W-1:0]  m_lowest_rate_reg, m_lowest_rate_next;
    logic [RATE_W-1:0]  m_highest_rate_reg, m_highest_rate_next;
    logic [RATE_W-1:0]  m_average_rate_reg, m_average_rate_next;

    div_cmd_t           div_cmd;
    logic               div_busy;
    logic [RATE_W-1:0]  div_quot;

    logic               ram_we;
    logic [RATE_W-1:0]  ram_rdata;

    logic               accept;
    logic               record;
    logic               out_load;
    logic [RATE_W-1:0]  q_rate;
    logic [RATE_W-1:0]  old_value;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign record    = (seen_reg != 2'd0);
    assign out_load  = (state_reg == S_AVG) && !div_busy && (!m_valid_reg || m_ready);
    assign q_rate    = sat_reg ? RATE_MAX : div_quot;

    // The ring fills in slot order, so a slot holds data only once the ring has wrapped.
    assign old_value = full_reg ? ram_rdata : '0;

    // Rate: the quotient overflows exactly when tps >> 16 reaches the interval, which also
    // covers a zero interval. Otherwise tps >> 16 is a valid starting remainder.
    // Average: sum >> 24 is always below the depth, as the sum holds at most WINDOW_DEPTH RATE_W-bit entries.
    always_comb begin
        div_cmd.start = accept || (state_reg == S_UPDATE);
        if (state_reg == S_UPDATE) begin
            div_cmd.rem_init = RATE_W'(sum_reg[SUM_W-1:RATE_W]);
            div_cmd.numer    = sum_reg[RATE_W-1:0];
            div_cmd.divisor  = RATE_W'(WINDOW_DEPTH);
        end else begin
            div_cmd.rem_init = RATE_W'(tps_reg[TPS_W-1:16]);
            div_cmd.numer    = {tps_reg[15:0], 8'd0};
            div_cmd.divisor  = s_interval_ticks;
        end
    end

    always_comb begin
        state_next            = state_reg;
        tps_next              = cfg_valid ? cfg_ticks_per_second : tps_reg;
        sat_next              = sat_reg;
        seen_next             = seen_reg;
        slot_next             = slot_reg;
        full_next             = full_reg;
        sum_next              = sum_reg;
        min_next              = min_reg;
        max_next              = max_reg;
        rate_next             = rate_reg;
        recorded_next         = recorded_reg;
        ram_we                = 1'b0;
        m_valid_next          = m_valid_reg && !m_ready;
        m_frame_rate_next     = m_frame_rate_reg;
        m_rate_recorded_next  = m_rate_recorded_reg;
        m_rate_saturated_next = m_rate_saturated_reg;
        m_lowest_rate_next    = m_lowest_rate_reg;
        m_highest_rate_next   = m_highest_rate_reg;
        m_average_rate_next   = m_average_rate_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sat_next   = {8'd0, tps_reg[TPS_W-1:16]} >= s_interval_ticks;
                    state_next = S_RATE;
                end
            end
            S_RATE: begin
                if (!div_busy) begin
                    rate_next     = q_rate;
                    recorded_next = record;
                    seen_next     = (seen_reg == 2'd2) ? 2'd2 : seen_reg + 2'd1;
                    if (record) begin
                        ram_we   = 1'b1;
                        sum_next = sum_reg - SUM_W'(old_value) + SUM_W'(q_rate);
                        if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) begin
                            slot_next = '0;
                            full_next = 1'b1;
                        end else begin
                            slot_next = slot_reg + 1'b1;
                        end
                        if (q_rate < min_reg) begin
                            min_next = q_rate;
                        end
                        if (q_rate > max_reg) begin
                            max_next = q_rate;
                        end
                    end
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                state_next = S_AVG;
            end
            S_AVG: begin
                if (out_load) begin
                    m_valid_next          = 1'b1;
                    m_frame_rate_next     = rate_reg;
                    m_rate_recorded_next  = recorded_reg;
                    m_rate_saturated_next = sat_reg;
                    m_lowest_rate_next    = min_reg;
                    m_highest_rate_next   = max_reg;
                    m_average_rate_next   = div_quot;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tps_reg     <= TPS_RESET;
            seen_reg    <= 2'd0;
            slot_reg    <= '0;
            full_reg    <= 1'b0;
            sum_reg     <= '0;
            min_reg     <= MIN_RESET;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tps_reg     <= tps_next;
            seen_reg    <= seen_next;
            slot_reg    <= slot_next;
            full_reg    <= full_next;
            sum_reg     <= sum_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sat_reg              <= sat_next;
        rate_reg             <= rate_next;
        recorded_reg         <= recorded_next;
        m_frame_rate_reg     <= m_frame_rate_next;
        m_rate_recorded_reg  <= m_rate_recorded_next;
        m_rate_saturated_reg <= m_rate_saturated_next;
        m_lowest_rate_reg    <= m_lowest_rate_next;
        m_highest_rate_reg   <= m_highest_rate_next;
        m_average_rate_reg   <= m_average_rate_next;
    end

    frwm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .div_cmd  (div_cmd),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // The old entry is read when the request is taken and used when the rate is known.
    frwm_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (q_rate),
        .re    (accept),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign m_valid          = m_valid_reg;
    assign m_frame_rate     = m_frame_rate_reg;
    assign m_rate_recorded  = m_rate_recorded_reg;
    assign m_rate_saturated = m_rate_saturated_reg;
    assign m_lowest_rate    = m_lowest_rate_reg;
    assign m_highest_rate   = m_highest_rate_reg;
    assign m_average_rate   = m_average_rate_reg;

    `FRWM_ASSERT_NEXT(a_one_item, aclk, aresetn, accept, !s_ready,
        "second request taken while one is in progress")
    `FRWM_ASSERT_SAME(a_div_free, aclk, aresetn, accept, !div_busy,
        "request taken while the divider is still busy")
    `FRWM_ASSERT_SAME(a_min_max, aclk, aresetn, m_valid_reg && m_rate_recorded_reg,
        m_lowest_rate_reg <= m_highest_rate_reg, "recorded minimum exceeds maximum")
    `FRWM_ASSERT_SAME(a_sum_bound, aclk, aresetn, 1'b1,
        (sum_reg >> RATE_W) < SUM_W'(WINDOW_DEPTH), "window sum out of range")

endmodule

`default_nettype wire
